/* design/uer_pkg.sv */
// Shared types and constants for the ultrasonic echo ranger.
`timescale 1ns / 1ps

package uer_pkg;

   localparam int TRIG_WIDTH  = 8;
   localparam int COUNT_WIDTH = 20;
   localparam int DIST_WIDTH  = 21;
   localparam int PHASE_WIDTH = 3;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // Register index, taken from the word address bit of paddr.
   localparam logic REG_TRIGGER_WIDTH = 1'b0;
   localparam logic REG_TIMEOUT       = 1'b1;

   localparam logic [TRIG_WIDTH-1:0]  TRIGGER_WIDTH_RESET = 8'd10;
   localparam logic [COUNT_WIDTH-1:0] TIMEOUT_RESET       = 20'd100000;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX           = '1;

   // Phases of one measurement.
   localparam logic [PHASE_WIDTH-1:0] PH_IDLE      = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_TRIG      = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_WAIT_LOW  = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_WAIT_HIGH = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_MEASURE   = 3'd4;

   // width*100/58 = width*50/29. floor(x/29) = (x*ceil(2^31/29)) >> 31 for
   // x below 2^26; the factor 50 is folded into the reciprocal.
   localparam int SCALE_SHIFT = 31;
   localparam int SCALE_WIDTH = 32;
   localparam logic [SCALE_WIDTH-1:0] SCALE_MULT = 32'd3702558050;
   localparam int PROD_WIDTH = COUNT_WIDTH + SCALE_WIDTH;

   typedef struct packed {
      logic start_req;
      logic echo_level;
      logic power_ok;
   } uer_req_type;

   typedef struct packed {
      logic [TRIG_WIDTH-1:0]  trigger_width_us;
      logic [COUNT_WIDTH-1:0] timeout_us;
   } uer_cfg_type;

   typedef struct packed {
      logic                   trigger_level;
      logic                   done_res;
      logic                   timed_out;
      logic                   skipped;
      logic [COUNT_WIDTH-1:0] pulse_us;
   } uer_result_type;

endpackage

/* design/uer_csr.sv */
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module uer_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [uer_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [uer_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [uer_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready,
   output uer_pkg::uer_cfg_type               cfg
);
   import uer_pkg::*;

   logic [TRIG_WIDTH-1:0]  trig_width_ff;
   logic [COUNT_WIDTH-1:0] timeout_ff;
   logic                   write_en;
   logic                   reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_width_ff <= TRIGGER_WIDTH_RESET;
         timeout_ff    <= TIMEOUT_RESET;
      end else if (write_en) begin
         unique case (reg_sel)
            REG_TRIGGER_WIDTH: trig_width_ff <= csr_pwdata[TRIG_WIDTH-1:0];
            REG_TIMEOUT:       timeout_ff    <= csr_pwdata[COUNT_WIDTH-1:0];
            default:           timeout_ff    <= timeout_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_TRIGGER_WIDTH: csr_prdata = {{(CSR_DATA_WIDTH-TRIG_WIDTH){1'b0}}, trig_width_ff};
         REG_TIMEOUT:       csr_prdata = {{(CSR_DATA_WIDTH-COUNT_WIDTH){1'b0}}, timeout_ff};
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.trigger_width_us = trig_width_ff;
   assign cfg.timeout_us       = timeout_ff;

endmodule

/* design/uer_step.sv */
// Measurement sequencer: phase and counters, advanced by one tick per request.
`timescale 1ns / 1ps

module uer_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  uer_pkg::uer_req_type   req,
   input  uer_pkg::uer_cfg_type   cfg,
   output uer_pkg::uer_result_type res
);
   import uer_pkg::*;

   logic [PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic [TRIG_WIDTH-1:0]  trig_cnt_ff, trig_cnt_in;
   logic [COUNT_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [COUNT_WIDTH-1:0] width_ff, width_in;

   logic [TRIG_WIDTH-1:0]  trig_width_eff;
   logic [COUNT_WIDTH-1:0] timeout_eff;
   logic [TRIG_WIDTH-1:0]  trig_cnt_inc;
   logic                   waiting;
   logic                   echo_fell;

   assign trig_width_eff = (cfg.trigger_width_us == '0) ? TRIG_WIDTH'(1) : cfg.trigger_width_us;
   assign timeout_eff    = (cfg.timeout_us == '0) ? COUNT_WIDTH'(1) : cfg.timeout_us;
   assign trig_cnt_inc   = trig_cnt_ff + TRIG_WIDTH'(1);

   always_comb begin
      phase_in    = phase_ff;
      trig_cnt_in = trig_cnt_ff;
      elapsed_in  = elapsed_ff;
      width_in    = width_ff;
      res         = '0;
      waiting     = 1'b0;
      echo_fell   = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (req.start_req && !req.power_ok) begin
               res.done_res = 1'b1;
               res.skipped  = 1'b1;
            end else if (req.start_req) begin
               trig_cnt_in       = TRIG_WIDTH'(1);
               elapsed_in        = '0;
               width_in          = '0;
               phase_in          = (trig_width_eff == TRIG_WIDTH'(1)) ? PH_WAIT_LOW : PH_TRIG;
               res.trigger_level = 1'b1;
            end
         end
         PH_TRIG: begin
            trig_cnt_in       = trig_cnt_inc;
            res.trigger_level = 1'b1;
            if (trig_cnt_inc >= trig_width_eff || trig_cnt_inc == '0) begin
               phase_in = PH_WAIT_LOW;
            end
         end
         PH_WAIT_LOW: begin
            waiting = 1'b1;
            if (!req.echo_level) begin
               phase_in = PH_WAIT_HIGH;
            end
         end
         PH_WAIT_HIGH: begin
            waiting = 1'b1;
            if (req.echo_level) begin
               width_in = COUNT_WIDTH'(1);
               phase_in = PH_MEASURE;
            end
         end
         PH_MEASURE: begin
            if (req.echo_level) begin
               waiting = 1'b1;
               if (width_ff != COUNT_MAX) begin
                  width_in = width_ff + COUNT_WIDTH'(1);
               end
            end else begin
               echo_fell    = 1'b1;
               phase_in     = PH_IDLE;
               res.done_res = 1'b1;
               res.pulse_us = width_ff;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // Timeout budget runs only on waiting ticks that did not finish.
      if (waiting && !echo_fell) begin
         if (elapsed_ff != COUNT_MAX) begin
            elapsed_in = elapsed_ff + COUNT_WIDTH'(1);
         end
         if (elapsed_in >= timeout_eff) begin
            phase_in      = PH_IDLE;
            res.done_res  = 1'b1;
            res.timed_out = 1'b1;
            res.pulse_us  = width_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         trig_cnt_ff <= '0;
         elapsed_ff  <= '0;
         width_ff    <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         trig_cnt_ff <= trig_cnt_in;
         elapsed_ff  <= elapsed_in;
         width_ff    <= width_in;
      end
   end

endmodule

/* design/uer_scale.sv */
// Pulse width to hundredths of a centimeter by reciprocal multiplication.
`timescale 1ns / 1ps

module uer_scale (
   input  logic [uer_pkg::COUNT_WIDTH-1:0] pulse_us,
   output logic [uer_pkg::DIST_WIDTH-1:0]  distance_centi_cm
);
   import uer_pkg::*;

   logic [PROD_WIDTH-1:0] product;

   assign product           = PROD_WIDTH'(pulse_us) * PROD_WIDTH'(SCALE_MULT);
   assign distance_centi_cm = product[SCALE_SHIFT +: DIST_WIDTH];

endmodule

/* design/ultrasonic_echo_ranger_core.sv */
// Top level of the ultrasonic echo ranger: stream ports, pipeline and CSRs.
`timescale 1ns / 1ps

// Ultrasonic echo ranger. Feed one request per microsecond tick on the req_
// stream (start, sampled echo pin, sensor power); every request yields exactly
// one response on the rsp_ stream carrying the trigger pin level for that
// tick and, on the tick a measurement ends, the done flag, the timeout and
// skip flags, the echo width in microseconds and the distance in hundredths
// of a centimeter (width*100/58, truncated). A start without sensor power
// answers at once with done and skipped. The block takes one request per
// clock while the rsp_ side does not stall, and a response passes through
// an input register, the sequencer stage that updates phase and counters,
// and the result register behind the distance multiplier. The sequencer's
// state update as each request enters its stage is what lets ticks follow
// back to back; both stream sides stall independently. Registers: trigger
// width at 0x0 (8 bits, reset 10, zero means one tick) and timeout at 0x4
// (20 bits, reset 100000, zero means one tick); write them only while idle.
module ultrasonic_echo_ranger_core (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: [0] start_req, [1] echo_level, [2] power_ok, [7:3] zero
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,
   // rsp_tdata: [0] trigger_level, [20:1] pulse_us, [41:21] distance_centi_cm,
   // [47:42] zero
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [47:0]                        rsp_tdata,
   // rsp_tuser: [0] done_res, [1] timed_out, [2] skipped
   output logic [2:0]                         rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [uer_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [uer_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [uer_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);
   import uer_pkg::*;

   uer_cfg_type    cfg;
   uer_result_type step_res;
   logic [DIST_WIDTH-1:0] dist_calc;

   // Stage 1: accepted request.
   logic        s1_valid_ff, s1_valid_in;
   uer_req_type s1_req_ff;
   // Stage 2: sequencer result.
   logic           s2_valid_ff, s2_valid_in;
   uer_result_type s2_res_ff;
   // Stage 3: response register.
   logic                  s3_valid_ff, s3_valid_in;
   uer_result_type        s3_res_ff;
   logic [DIST_WIDTH-1:0] s3_dist_ff;

   logic req_accept;
   logic s2_load;
   logic s3_load;

   uer_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Advance each stage when the stage ahead is empty or moving on.
   assign s3_load    = s2_valid_ff & (~s3_valid_ff | rsp_tready);
   assign s2_load    = s1_valid_ff & (~s2_valid_ff | s3_load);
   assign req_tready = ~s1_valid_ff | s2_load;
   assign req_accept = req_tvalid & req_tready;

   assign s1_valid_in = req_accept | (s1_valid_ff & ~s2_load);
   assign s2_valid_in = s2_load | (s2_valid_ff & ~s3_load);
   assign s3_valid_in = s3_load | (s3_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Payload registers: load on the handshake, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff.start_req  <= req_tdata[0];
         s1_req_ff.echo_level <= req_tdata[1];
         s1_req_ff.power_ok   <= req_tdata[2];
      end
      if (s2_load) begin
         s2_res_ff <= step_res;
      end
      if (s3_load) begin
         s3_res_ff  <= s2_res_ff;
         s3_dist_ff <= dist_calc;
      end
   end

   // Sequencer state moves exactly once per request, as it enters stage 2.
   uer_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (s2_load),
      .req     (s1_req_ff),
      .cfg     (cfg),
      .res     (step_res)
   );

   uer_scale u_scale (
      .pulse_us          (s2_res_ff.pulse_us),
      .distance_centi_cm (dist_calc)
   );

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = {6'b0, s3_dist_ff, s3_res_ff.pulse_us, s3_res_ff.trigger_level};
   assign rsp_tuser  = {s3_res_ff.skipped, s3_res_ff.timed_out, s3_res_ff.done_res};

`ifndef ASSERT_OFF
   // A result without done carries no measurement.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[41:1] == '0 && rsp_tuser[2:1] == '0))
      else $error("idle response carries measurement data");

   // The trigger pin is never driven on a finishing tick.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> !rsp_tdata[0])
      else $error("trigger driven on done tick");

   // Timeout and skip are exclusive outcomes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[1] && rsp_tuser[2]))
      else $error("timed_out and skipped both set");

   // A request waiting in stage 1 stays there until the sequencer takes it.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_load) |=> (s1_valid_ff && $stable(s1_req_ff)))
      else $error("stalled request lost");
`endif

endmodule
